FILE: sv/lhs_pkg.sv
// Package for the letter histogram similarity block: shared constants,
// controller state encoding and the command/status structs.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package lhs_pkg;

  // Alphabet and field widths
  localparam int ALPHABET_SIZE = 26;
  localparam int ADDR_W        = $clog2(ALPHABET_SIZE);
  localparam int LETTER_W      = 5;
  localparam int DIFF_W        = 9;
  localparam int DIFF_MAX      = 511;
  localparam int TALLY_W       = 16;
  localparam int IN_DATA_W     = 8;
  localparam int OUT_DATA_W    = 32;

  // Controller states, one-hot
  typedef enum logic [1:0] {
    ST_IDLE   = 2'b01,
    ST_UPDATE = 2'b10
  } lhs_state_t;

  // Controller -> datapath
  typedef struct packed {
    logic load;    // request accepted, capture it and read both count stores
    logic commit;  // apply the update for the captured letter
  } lhs_cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic result_blocked;  // result due but the output register is still full
  } lhs_status_t;

endpackage

`default_nettype wire

FILE: sv/letter_histogram_similarity.sv
// Top level of the letter histogram similarity block: wires the controller
// to the datapath and packs the stream ports.
// Depends on lhs_pkg, lhs_ctrl, lhs_datapath.
//
//   channel | dir | tdata                         | tuser   | tlast
//   in_     | in  | [4:0] letter                  | action  | word_end
//   out_    | out | [0] is_similar [9:1] diff     | -       | -
//           |     | [25:10] similar_tally         |         |
//
// Each request is accepted, reading both count stores at the letter, then
// committed, applying the count, length, distance and tally update.
// The L1 distance is kept incrementally, so a word end costs no extra walk.
// A candidate word end waits in the commit cycle while the output register
// still holds an untaken result. Reset (rst_n low, synchronous) empties both
// stores through their valid bits at once; no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module letter_histogram_similarity #(
  parameter int MAX_WORD_LEN = 255
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  input  wire logic [lhs_pkg::IN_DATA_W-1:0]     in_tdata,   // [4:0] letter
  input  wire logic                              in_tuser,   // action
  input  wire logic                              in_tlast,   // word_end
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  output logic      [lhs_pkg::OUT_DATA_W-1:0]    out_tdata   // is_similar, difference,
                                                             // similar_tally
);
  import lhs_pkg::*;

  lhs_cmd_t            cmd;
  lhs_status_t         status;
  logic                is_similar;
  logic [DIFF_W-1:0]   difference;
  logic [TALLY_W-1:0]  similar_tally;

  lhs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .status    (status),
    .cmd       (cmd)
  );

  lhs_datapath #(.MAX_WORD_LEN(MAX_WORD_LEN)) u_datapath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .status            (status),
    .in_action         (in_tuser),
    .in_letter         (in_tdata[LETTER_W-1:0]),
    .in_word_end       (in_tlast),
    .out_tvalid        (out_tvalid),
    .out_tready        (out_tready),
    .out_is_similar    (is_similar),
    .out_difference    (difference),
    .out_similar_tally (similar_tally)
  );

  // Pack the result, zero fill to whole bytes
  assign out_tdata = {{(OUT_DATA_W - 1 - DIFF_W - TALLY_W){1'b0}},
                      similar_tally, difference, is_similar};

endmodule

`default_nettype wire

FILE: sv/lhs_count_store.sv
// Per-letter count store: 26-entry memory with registered read and a valid
// bit per entry so a whole word can be cleared at once.
// Depends on lhs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lhs_count_store #(
  parameter int DATA_W = 8
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      rd_en,
  input  wire logic [lhs_pkg::ADDR_W-1:0] rd_addr,
  output logic      [DATA_W-1:0]          rd_data,
  input  wire logic                      wr_en,
  input  wire logic [lhs_pkg::ADDR_W-1:0] wr_addr,
  input  wire logic [DATA_W-1:0]          wr_data,
  input  wire logic                      clr
);
  import lhs_pkg::*;

  logic [DATA_W-1:0]        mem [ALPHABET_SIZE];
  logic [ALPHABET_SIZE-1:0] valid_r;
  logic [ALPHABET_SIZE-1:0] valid_nxt;
  logic [DATA_W-1:0]        rd_data_r;
  logic                     rd_valid_r;

  // Clear drops every entry; a write in the same cycle survives
  always_comb begin
    valid_nxt = clr ? '0 : valid_r;
    if (wr_en) begin
      valid_nxt[wr_addr] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= '0;
      rd_valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      if (rd_en) begin
        rd_valid_r <= valid_r[rd_addr];
      end
    end
  end

  // Memory array, write and registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  // Entries not written since the last clear read as zero
  assign rd_data = rd_valid_r ? rd_data_r : '0;

endmodule

`default_nettype wire

FILE: sv/lhs_ctrl.sv
// Controller for the letter histogram similarity block: two-state sequencer
// that accepts a request and then commits its update.
// Depends on lhs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lhs_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_tvalid,
  output logic                      in_tready,
  input  wire lhs_pkg::lhs_status_t status,
  output lhs_pkg::lhs_cmd_t         cmd
);
  import lhs_pkg::*;

  lhs_state_t state_r;
  lhs_state_t state_nxt;

  assign in_tready  = (state_r == ST_IDLE);
  assign cmd.load   = in_tvalid && in_tready;
  assign cmd.commit = (state_r == ST_UPDATE) && !status.result_blocked;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (cmd.load) state_nxt = ST_UPDATE;
      end
      ST_UPDATE: begin
        if (cmd.commit) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: sv/lhs_datapath.sv
// Datapath for the letter histogram similarity block: count stores, word
// lengths, running L1 distance, tally and the output register.
// Depends on lhs_pkg and lhs_count_store.
`timescale 1ns / 1ps
`default_nettype none

module lhs_datapath #(
  parameter int MAX_WORD_LEN = 255
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire lhs_pkg::lhs_cmd_t           cmd,
  output lhs_pkg::lhs_status_t             status,
  input  wire logic                        in_action,
  input  wire logic [lhs_pkg::LETTER_W-1:0] in_letter,
  input  wire logic                        in_word_end,
  output logic                             out_tvalid,
  input  wire logic                        out_tready,
  output logic                             out_is_similar,
  output logic      [lhs_pkg::DIFF_W-1:0]   out_difference,
  output logic      [lhs_pkg::TALLY_W-1:0]  out_similar_tally
);
  import lhs_pkg::*;

  localparam int CW   = $clog2(MAX_WORD_LEN + 1);
  localparam int SUMW = CW + 5;                       // 26 counts of CW bits
  localparam int DW   = (SUMW > DIFF_W) ? SUMW : DIFF_W;
  localparam logic [CW-1:0] MAXV = CW'(MAX_WORD_LEN);

  // Captured request
  logic                act_r, last_r, clr_r;
  logic [LETTER_W-1:0] letter_r;

  // Word state
  logic [CW-1:0]      ref_len_r, cand_len_r;
  logic [SUMW-1:0]    ref_sum_r, cand_sum_r;   // total of each store's counts
  logic [SUMW-1:0]    dist_r;                  // sum of |cand - ref|
  logic [TALLY_W-1:0] tally_r;
  logic               word_start_r;

  // Output register
  logic               out_valid_r;
  logic               sim_r;
  logic [DIFF_W-1:0]  diff_r;
  logic [TALLY_W-1:0] otally_r;

  logic [CW-1:0]      ref_rd, cand_rd;
  logic               rd_en, in_range, res_item;
  logic [CW-1:0]      r_old, c_old, own_old, other_old, own_new;
  logic               own_bump;
  logic [CW-1:0]      len_old, len_new;
  logic [SUMW-1:0]    sum_old, sum_new, s_base, s_new;
  logic [DW-1:0]      s_ext;
  logic               similar;
  logic [TALLY_W-1:0] tally_base, tally_new;
  logic               ref_wr, cand_wr, ref_clr, cand_clr;

  assign rd_en = cmd.load && (in_letter < LETTER_W'(ALPHABET_SIZE));

  lhs_count_store #(.DATA_W(CW)) u_ref_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (rd_en),
    .rd_addr (in_letter[ADDR_W-1:0]),
    .rd_data (ref_rd),
    .wr_en   (ref_wr),
    .wr_addr (letter_r[ADDR_W-1:0]),
    .wr_data (own_new),
    .clr     (ref_clr)
  );

  lhs_count_store #(.DATA_W(CW)) u_cand_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (rd_en),
    .rd_addr (in_letter[ADDR_W-1:0]),
    .rd_data (cand_rd),
    .wr_en   (cand_wr),
    .wr_addr (letter_r[ADDR_W-1:0]),
    .wr_data (own_new),
    .clr     (cand_clr)
  );

  // Capture the request
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act_r    <= in_action;
      letter_r <= in_letter;
      last_r   <= in_word_end;
      clr_r    <= word_start_r;
    end
  end

  // Update for one letter; a word start treats the own store as empty
  always_comb begin
    in_range  = letter_r < LETTER_W'(ALPHABET_SIZE);
    res_item  = act_r && last_r;
    r_old     = (clr_r && !act_r) ? '0 : ref_rd;
    c_old     = (clr_r && act_r) ? '0 : cand_rd;
    own_old   = act_r ? c_old : r_old;
    other_old = act_r ? r_old : c_old;
    own_bump  = in_range && (own_old < MAXV);
    own_new   = own_old + CW'(own_bump);

    len_old   = clr_r ? '0 : (act_r ? cand_len_r : ref_len_r);
    len_new   = len_old + CW'(in_range && (len_old < MAXV));
    sum_old   = clr_r ? '0 : (act_r ? cand_sum_r : ref_sum_r);
    sum_new   = sum_old + SUMW'(own_bump);

    // Empty own store: distance is the other store's total
    s_base = clr_r ? (act_r ? ref_sum_r : cand_sum_r) : dist_r;
    if (!own_bump) begin
      s_new = s_base;
    end else if (own_old >= other_old) begin
      s_new = s_base + SUMW'(1);
    end else begin
      s_new = s_base - SUMW'(1);
    end
    s_ext = DW'(s_new);

    similar    = (s_new <= SUMW'(1)) ||
                 ((s_new == SUMW'(2)) && (len_new == ref_len_r));
    tally_base = (clr_r && !act_r) ? '0 : tally_r;
    tally_new  = (similar && (tally_base != {TALLY_W{1'b1}})) ?
                 tally_base + TALLY_W'(1) : tally_base;

    ref_wr   = cmd.commit && !act_r && in_range;
    cand_wr  = cmd.commit && act_r && in_range;
    ref_clr  = cmd.commit && clr_r && !act_r;
    cand_clr = cmd.commit && clr_r && act_r;
  end

  assign status.result_blocked = res_item && out_valid_r && !out_tready;

  // Word state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ref_len_r    <= '0;
      cand_len_r   <= '0;
      ref_sum_r    <= '0;
      cand_sum_r   <= '0;
      dist_r       <= '0;
      tally_r      <= '0;
      word_start_r <= 1'b1;
    end else if (cmd.commit) begin
      word_start_r <= last_r;
      dist_r       <= s_new;
      if (act_r) begin
        cand_len_r <= len_new;
        cand_sum_r <= sum_new;
        if (last_r) tally_r <= tally_new;
      end else begin
        ref_len_r <= len_new;
        ref_sum_r <= sum_new;
        tally_r   <= tally_base;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.commit && res_item) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit && res_item) begin
      sim_r    <= similar;
      diff_r   <= (s_ext > DW'(DIFF_MAX)) ? DIFF_W'(DIFF_MAX) : s_ext[DIFF_W-1:0];
      otally_r <= tally_new;
    end
  end

  assign out_tvalid        = out_valid_r;
  assign out_is_similar    = sim_r;
  assign out_difference    = diff_r;
  assign out_similar_tally = otally_r;

  // A result appears only from a committed candidate word end
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(cmd.commit && act_r && last_r))
    else $error("result without candidate word end");

  // A new result never overwrites one still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.commit && res_item) |-> !(out_valid_r && !out_tready))
    else $error("result overwritten");

  // Similar words have a small distance
  a_similar_dist: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(sim_r && (diff_r > DIFF_W'(2))))
    else $error("similar flag with large distance");

  // Commit and load never happen together
  a_load_commit: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.load && cmd.commit))
    else $error("load and commit in one cycle");

endmodule

`default_nettype wire

FILE: dv/tb_letter_histogram_similarity.sv
// Self-checking testbench for letter_histogram_similarity: a directed table, then
// random word streams under changing back-pressure, each result checked against a
// letter-count predictor. Depends on lhs_pkg and the letter_histogram_similarity RTL.
`timescale 1ns / 1ps

module tb_letter_histogram_similarity;
  import lhs_pkg::*;

  localparam int WORD_LEN_CAP = 255;
  localparam int IN_W         = IN_DATA_W;
  localparam int OUT_W        = OUT_DATA_W;
  localparam int TALLY_MAX    = (1 << TALLY_W) - 1;
  localparam int HOLD_CYCLES  = 300;
  localparam int SETTLE       = 20;

  // Word selector carried on in_tuser
  localparam logic ACT_REF  = 1'b0;
  localparam logic ACT_CAND = 1'b1;

  typedef struct packed {
    logic                act;
    logic [LETTER_W-1:0] code;
  } letter_t;

  typedef struct packed {
    logic               sim;
    logic [DIFF_W-1:0]  diff;
    logic [TALLY_W-1:0] tally;
  } score_t;

  typedef struct packed {
    logic                act;
    logic [LETTER_W-1:0] code;
    logic                last;
    logic                typed;  // expectation written out below
    score_t              want;
  } row_t;

  // Directed requests: act, letter, word_end, typed, {similar, difference, tally}
  localparam row_t DIRECTED [23] = '{
    // candidate before any reference: one letter against an empty store
    {ACT_CAND, 5'd0,  1'b1, 1'b1, 1'b1, 9'd1, 16'd1},
    // two of the last letter: distance two, lengths differ
    {ACT_CAND, 5'd25, 1'b0, 1'b0, 1'b0, 9'd0, 16'd0},
    {ACT_CAND, 5'd25, 1'b1, 1'b1, 1'b0, 9'd2, 16'd1},
    // reference ABC clears the tally
    {ACT_REF,  5'd0,  1'b0, 1'b0, 1'b0, 9'd0, 16'd0},
    {ACT_REF,  5'd1,  1'b0, 1'b0, 1'b0, 9'd0, 16'd0},
    {ACT_REF,  5'd2,  1'b1, 1'b0, 1'b0, 9'd0, 16'd0},
    // anagram
    {ACT_CAND, 5'd2,  1'b0, 1'b0, 1'b0, 9'd0, 16'd0},
    {ACT_CAND, 5'd1,  1'b0, 1'b0, 1'b0, 9'd0, 16'd0},
    {ACT_CAND, 5'd0,  1'b1, 1'b1, 1'b1, 9'd0, 16'd1},
    // one substitution, equal lengths
    {ACT_CAND, 5'd0,  1'b0, 1'b0, 1'b0, 9'd0, 16'd0},
    {ACT_CAND, 5'd1,  1'b0, 1'b0, 1'b0, 9'd0, 16'd0},
    {ACT_CAND, 5'd3,  1'b1, 1'b0, 1'b0, 9'd0, 16'd0},
    // codes above Z are skipped
    {ACT_CAND, 5'd0,  1'b0, 1'b0, 1'b0, 9'd0, 16'd0},
    {ACT_CAND, 5'd31, 1'b0, 1'b0, 1'b0, 9'd0, 16'd0},
    {ACT_CAND, 5'd1,  1'b0, 1'b0, 1'b0, 9'd0, 16'd0},
    {ACT_CAND, 5'd2,  1'b1, 1'b0, 1'b0, 9'd0, 16'd0},
    {ACT_CAND, 5'd26, 1'b1, 1'b0, 1'b0, 9'd0, 16'd0},
    // mixed word: a reference letter lands mid-candidate
    {ACT_CAND, 5'd0,  1'b0, 1'b0, 1'b0, 9'd0, 16'd0},
    {ACT_REF,  5'd3,  1'b0, 1'b0, 1'b0, 9'd0, 16'd0},
    {ACT_CAND, 5'd1,  1'b0, 1'b0, 1'b0, 9'd0, 16'd0},
    {ACT_CAND, 5'd2,  1'b1, 1'b0, 1'b0, 9'd0, 16'd0},
    // reference of only a skipped code empties the store
    {ACT_REF,  5'd30, 1'b1, 1'b0, 1'b0, 9'd0, 16'd0},
    {ACT_CAND, 5'd0,  1'b1, 1'b0, 1'b0, 9'd0, 16'd0}
  };

  logic             clk;
  logic             rst_n      = 1'b0;
  logic             in_tvalid  = 1'b0;
  logic             in_tready;
  logic [IN_W-1:0]  in_tdata   = '0;
  logic             in_tuser   = 1'b0;
  logic             in_tlast   = 1'b0;
  logic             out_tvalid;
  logic             out_tready = 1'b0;
  logic [OUT_W-1:0] out_tdata;

  // Predictor state
  int unsigned ref_counts  [ALPHABET_SIZE] = '{default: 0};
  int unsigned cand_counts [ALPHABET_SIZE] = '{default: 0};
  int unsigned ref_len    = 0;
  int unsigned cand_len   = 0;
  int unsigned sim_tally  = 0;
  bit          word_start = 1'b1;

  score_t  pending_scores[$];
  letter_t word_q[$];
  letter_t ref_word[$];
  int      errors      = 0;
  int      sent        = 0;
  int      tx_idle_pct = 0;
  int      rx_idle_pct = 0;
  logic    hold_flip   = 1'b0;
  logic    hold_seen   = 1'b0;
  int      hold_left   = 0;

  letter_histogram_similarity #(
    .MAX_WORD_LEN(WORD_LEN_CAP)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),    // [4:0] letter
    .in_tuser  (in_tuser),    // action
    .in_tlast  (in_tlast),    // word_end
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)    // [0] is_similar, [9:1] difference, [25:10] similar_tally
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #30000000;
    $display("tb_letter_histogram_similarity failed");
    $finish;
  end

  // ---------------------------------------------------------------- predictor

  function automatic int unsigned bump(input int unsigned v);
    return (v < WORD_LEN_CAP) ? v + 1 : v;
  endfunction

  // Apply one letter request; returns 1 when it closes a candidate word
  function automatic logic score_letter(input letter_t l, input logic last,
                                        output score_t res);
    int unsigned sum;
    logic        similar;
    sum = 0;
    res = '0;
    if (word_start) begin
      if (l.act == ACT_CAND) begin
        foreach (cand_counts[i]) cand_counts[i] = 0;
        cand_len = 0;
      end else begin
        foreach (ref_counts[i]) ref_counts[i] = 0;
        ref_len   = 0;
        sim_tally = 0;
      end
    end
    word_start = last;
    if (l.code < ALPHABET_SIZE) begin
      if (l.act == ACT_CAND) begin
        cand_counts[l.code] = bump(cand_counts[l.code]);
        cand_len            = bump(cand_len);
      end else begin
        ref_counts[l.code] = bump(ref_counts[l.code]);
        ref_len            = bump(ref_len);
      end
    end
    if (l.act == ACT_REF || !last) return 1'b0;
    foreach (cand_counts[i])
      sum += (cand_counts[i] > ref_counts[i]) ? cand_counts[i] - ref_counts[i]
                                              : ref_counts[i] - cand_counts[i];
    similar = (sum <= 1) || (sum == 2 && cand_len == ref_len);
    if (similar && sim_tally < TALLY_MAX) sim_tally++;
    res.sim   = similar;
    res.diff  = (sum > DIFF_MAX) ? DIFF_W'(DIFF_MAX) : DIFF_W'(sum);
    res.tally = TALLY_W'(sim_tally);
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------- checking

  task automatic report_mismatch(input string what, input longint got, input longint want);
    errors++;
    $display("%0t: %s mismatch, got %0d expected %0d", $time, what, got, want);
  endtask

  task automatic check_score(input logic [OUT_W-1:0] data);
    score_t want;
    if (pending_scores.size() == 0) begin
      report_mismatch("unexpected result, tdata", data, 0);
    end else begin
      want = pending_scores.pop_front();
      if (data[0] !== want.sim)                   report_mismatch("is_similar", data[0], want.sim);
      if (data[DIFF_W:1] !== want.diff)          report_mismatch("difference", data[DIFF_W:1],
                                                                 want.diff);
      if (data[DIFF_W+TALLY_W:DIFF_W+1] !== want.tally)
        report_mismatch("similar_tally", data[DIFF_W+TALLY_W:DIFF_W+1], want.tally);
      if (data[OUT_W-1:DIFF_W+TALLY_W+1] !== '0)
        report_mismatch("tdata padding", data[OUT_W-1:DIFF_W+TALLY_W+1], 0);
    end
  endtask

  // Result side: random stalls, plus a long hold-off whenever hold_flip toggles
  always @(posedge clk) begin
    if (hold_flip != hold_seen) begin
      hold_seen <= hold_flip;
      hold_left <= HOLD_CYCLES;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
    out_tready <= (hold_flip == hold_seen) && (hold_left == 0) &&
                  ($urandom_range(99) >= rx_idle_pct);
    if (rst_n && out_tvalid && out_tready) check_score(out_tdata);
  end

  // ---------------------------------------------------------------- stimulus

  task automatic send_letter(input letter_t l, input logic last);
    score_t res;
    logic   due;
    while ($urandom_range(99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {{(IN_W-LETTER_W){1'b0}}, l.code};
    in_tuser  <= l.act;
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
    due = score_letter(l, last, res);
    if (due) pending_scores.push_back(res);
    sent++;
  endtask

  task automatic send_word();
    for (int i = 0; i < word_q.size(); i++) send_letter(word_q[i], i == word_q.size() - 1);
  endtask

  // Hold the sender off until every pending score has come back
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_scores.size() != 0) @(posedge clk);
  endtask

  function automatic letter_t rand_letter(input logic act);
    letter_t l;
    l.act  = act;
    l.code = LETTER_W'($urandom_range(ALPHABET_SIZE - 1));
    return l;
  endfunction

  task automatic add_run(input logic act, input int code, input int n);
    letter_t l;
    l.act  = act;
    l.code = LETTER_W'(code);
    repeat (n) word_q.push_back(l);
  endtask

  // One random word: mostly near-miss candidates, plus references, random candidates and some noise
  task automatic random_word();
    int      pick;
    int      a;
    letter_t tmp;
    word_q.delete();
    pick = $urandom_range(99);
    if (pick < 15) begin
      repeat ($urandom_range(1, 10)) word_q.push_back(rand_letter(ACT_REF));
      ref_word = word_q;
    end else if (pick < 65) begin
      // shuffled copy of the reference with up to two edits
      foreach (ref_word[i]) word_q.push_back('{ACT_CAND, ref_word[i].code});
      if (word_q.size() == 0) word_q.push_back(rand_letter(ACT_CAND));
      for (int i = word_q.size() - 1; i > 0; i--) begin
        a         = $urandom_range(i);
        tmp       = word_q[i];
        word_q[i] = word_q[a];
        word_q[a] = tmp;
      end
      repeat ($urandom_range(2)) begin
        a = $urandom_range(word_q.size() - 1);
        case ($urandom_range(2))
          0: begin
            if (word_q.size() > 1) begin
              word_q[a] = word_q[word_q.size() - 1];
              void'(word_q.pop_back());
            end
          end
          1: begin
            word_q.push_back(word_q[a]);
            word_q[a] = rand_letter(ACT_CAND);
          end
          default: begin
            word_q[a] = rand_letter(ACT_CAND);
          end
        endcase
      end
    end else if (pick < 80) begin
      repeat ($urandom_range(1, 10)) word_q.push_back(rand_letter(ACT_CAND));
    end else if (pick < 92) begin
      // noise: any code, either action per letter
      repeat ($urandom_range(1, 8)) word_q.push_back({1'($urandom_range(1)),
                                                      LETTER_W'($urandom_range(31))});
    end else begin
      word_q.push_back(rand_letter(ACT_CAND));
    end
    send_word();
  endtask

  task automatic random_words(input int n);
    int stop_at;
    stop_at = sent + n;
    while (sent < stop_at) random_word();
  endtask

  // ---------------------------------------------------------------- sequence

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table
    foreach (DIRECTED[i]) begin
      send_letter({DIRECTED[i].act, DIRECTED[i].code}, DIRECTED[i].last);
      if (DIRECTED[i].typed) pending_scores[pending_scores.size() - 1] = DIRECTED[i].want;
    end
    drain();

    // sender mostly busy, receiver stalls often
    tx_idle_pct = 14;
    rx_idle_pct <= 57;
    random_words(200);
    drain();

    // receiver mostly ready, after a long hold-off that backs up the input
    tx_idle_pct = 57;
    rx_idle_pct <= 14;
    hold_flip   <= ~hold_flip;
    repeat (40) send_letter(rand_letter(ACT_CAND), 1'b1);
    random_words(200);
    drain();

    // no idling: a long candidate against a two-letter reference saturates
    // the counts, the length and the difference, then random words
    tx_idle_pct = 0;
    rx_idle_pct <= 0;
    word_q.delete();
    add_run(ACT_REF, 0, 1);
    add_run(ACT_REF, 1, 1);
    send_word();
    word_q.delete();
    add_run(ACT_CAND, 2, 256);
    add_run(ACT_CAND, 3, 256);
    send_word();
    random_words(60);

    in_tvalid <= 1'b0;
    @(posedge clk);
    for (int i = 0; i < 5000 && pending_scores.size() != 0; i++) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (pending_scores.size() != 0)
      report_mismatch("missing results, count", 0, pending_scores.size());

    if (errors == 0) begin
      $display("tb_letter_histogram_similarity passed");
    end else begin
      $display("tb_letter_histogram_similarity failed");
    end
    $finish;
  end

endmodule

FILE: filelist.f
sv/lhs_pkg.sv
sv/lhs_count_store.sv
sv/lhs_ctrl.sv
sv/lhs_datapath.sv
sv/letter_histogram_similarity.sv
dv/tb_letter_histogram_similarity.sv
